// File: src/otst_pkg.sv
package otst_pkg;

	// widths of the beat fields
	localparam int unsigned REQ_W      = 2;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned TAG_PORT_W = 16;
	localparam int unsigned IDX_PORT_W = 4;

	// default table shape
	localparam int unsigned DEF_SLOT_COUNT = 16;
	localparam int unsigned DEF_TAG_BITS   = 16;

	// request codes, the remaining code is ignored
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

endpackage

// File: src/oneshot_timer_slot_table_top.sv
// One-shot timer slot table. The block holds SLOT_COUNT timer slots in a slot memory with
// one read and one write port (duration, elapsed time, tag per slot); a slot is busy while
// its duration is nonzero. An insert beat places its duration and tag in the lowest free
// slot and returns that slot with accepted set, or accepted clear when the table is full.
// A tick beat walks the slots from slot 0, adds tick_time (saturating) to the elapsed time
// of every busy slot it passes, and at the first slot whose elapsed time exceeds its
// duration reports fired, the slot and its tag, frees the slot and stops. A clear beat
// frees every slot at once; elapsed times are kept, so a reused slot starts from the
// elapsed time it had. Times are unsigned 16.16 seconds. Every input beat yields exactly
// one output beat. An insert or tick walks k slots (1 to SLOT_COUNT) before its result
// is ready: one slot per cycle through the single saturating adder and comparator, fed
// by the memory's one registered read port. A clear or an unused request code goes to
// the result without a walk. One request is in flight at a time; in_stall is high from
// acceptance until the result has moved into the output register, which can hold one
// finished beat while the next request is taken. A stalled output beat holds the sequencer
// until the output register frees up.
module oneshot_timer_slot_table_top
	import otst_pkg::*;
#(
	parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int unsigned TAG_BITS   = DEF_TAG_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [TIME_W-1:0]     wait_time,
	input  logic [TIME_W-1:0]     tick_time,
	input  logic [TAG_PORT_W-1:0] event_tag,

	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  accepted,
	output logic                  fired,
	output logic [IDX_PORT_W-1:0] slot_index,
	output logic [TAG_PORT_W-1:0] fired_tag
);

	localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	// captured request
	req_t                req_q;
	logic [TIME_W-1:0]   wait_q;
	logic [TIME_W-1:0]   tick_q;
	logic [TAG_BITS-1:0] tag_q;

	// slot memory, one entry per slot
	logic [TIME_W-1:0]   mem_dur [SLOT_COUNT];
	logic [TIME_W-1:0]   mem_el  [SLOT_COUNT];
	logic [TAG_BITS-1:0] mem_tag [SLOT_COUNT];

	// registered read data of the slot under evaluation
	logic [TIME_W-1:0]   dur_rd_q;
	logic [TIME_W-1:0]   el_rd_q;
	logic [TAG_BITS-1:0] tag_rd_q;

	// duration valid is dropped by clear and reset, elapsed valid by reset only;
	// a slot whose bit is low reads as zero
	logic [SLOT_COUNT-1:0] dur_vld_q;
	logic [SLOT_COUNT-1:0] el_vld_q;

	// slot now being evaluated
	logic [IDX_W-1:0] eidx_q;

	// result waiting for the output register
	logic                  res_acc_q;
	logic                  res_fire_q;
	logic [IDX_W-1:0]      res_idx_q;
	logic [TAG_PORT_W-1:0] res_tag_q;

	// output register
	logic                  out_valid_q;
	logic                  out_acc_q;
	logic                  out_fire_q;
	logic [IDX_PORT_W-1:0] out_idx_q;
	logic [TAG_PORT_W-1:0] out_tag_q;

	logic                  in_take;
	logic                  out_free;
	logic                  last;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;

	logic [TIME_W-1:0]     cur_dur;
	logic [TIME_W-1:0]     cur_el;
	logic [TIME_W:0]       sum;
	logic [TIME_W-1:0]     sat_el;
	logic                  ins_hit;
	logic                  slot_busy;
	logic                  fire_hit;
	logic                  stop;

	logic                  wr_en;
	logic [TIME_W-1:0]     wr_dur;
	logic [TIME_W-1:0]     wr_el;
	logic [TAG_BITS-1:0]   wr_tag;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign last = (eidx_q == IDX_W'(SLOT_COUNT - 1));

	// slot 0 is fetched on acceptance, then one slot ahead of evaluation
	assign rd_addr = (state_q == S_IDLE) ? '0 : eidx_q + IDX_W'(1);
	assign rd_en   = in_take || (state_q == S_WALK && !last);

	// shared datapath: one saturating add and one compare per slot
	assign cur_dur = dur_vld_q[eidx_q] ? dur_rd_q : '0;
	assign cur_el  = el_vld_q[eidx_q]  ? el_rd_q  : '0;
	assign sum     = {1'b0, cur_el} + {1'b0, tick_q};
	assign sat_el  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

	assign slot_busy = (cur_dur != '0);
	assign ins_hit   = (state_q == S_WALK) && (req_q == REQ_INSERT) && !slot_busy;
	assign fire_hit  = (state_q == S_WALK) && (req_q == REQ_TICK) && slot_busy
	                   && (sat_el > cur_dur);
	assign stop      = ins_hit || fire_hit || last;

	always_comb begin
		wr_en  = 1'b0;
		wr_dur = cur_dur;
		wr_el  = cur_el;
		wr_tag = tag_rd_q;
		if (state_q == S_WALK) begin
			case (req_q)
				REQ_INSERT: begin
					// stale elapsed time is kept on purpose
					if (ins_hit) begin
						wr_en  = 1'b1;
						wr_dur = wait_q;
						wr_tag = tag_q;
					end
				end
				REQ_TICK: begin
					if (slot_busy) begin
						wr_en = 1'b1;
						if (fire_hit) begin
							wr_dur = '0;
							wr_el  = '0;
						end else begin
							wr_el = sat_el;
						end
					end
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// slot memory, written at the evaluated slot and read one slot ahead
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_dur[eidx_q] <= wr_dur;
			mem_el[eidx_q]  <= wr_el;
			mem_tag[eidx_q] <= wr_tag;
		end
		if (rd_en) begin
			dur_rd_q <= mem_dur[rd_addr];
			el_rd_q  <= mem_el[rd_addr];
			tag_rd_q <= mem_tag[rd_addr];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q  <= req_t'(req_type);
			wait_q <= wait_time;
			tick_q <= tick_time;
			tag_q  <= TAG_BITS'(event_tag);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_vld_q <= '0;
			el_vld_q  <= '0;
		end else begin
			if (in_take && req_type == REQ_CLEAR) begin
				dur_vld_q <= '0;
			end else if (wr_en) begin
				dur_vld_q[eidx_q] <= 1'b1;
				el_vld_q[eidx_q]  <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			eidx_q     <= '0;
			res_acc_q  <= 1'b0;
			res_fire_q <= 1'b0;
			res_idx_q  <= '0;
			res_tag_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						eidx_q     <= '0;
						res_acc_q  <= 1'b0;
						res_fire_q <= 1'b0;
						res_idx_q  <= '0;
						res_tag_q  <= '0;
						// clear and the unused code finish without a walk
						if (req_type inside {REQ_INSERT, REQ_TICK}) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_WALK: begin
					if (stop) begin
						state_q    <= S_DONE;
						res_acc_q  <= ins_hit;
						res_fire_q <= fire_hit;
						res_idx_q  <= (ins_hit || fire_hit) ? eidx_q : '0;
						res_tag_q  <= fire_hit ? TAG_PORT_W'(tag_rd_q) : '0;
					end else begin
						eidx_q <= eidx_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_acc_q  <= res_acc_q;
			out_fire_q <= res_fire_q;
			out_idx_q  <= IDX_PORT_W'(res_idx_q);
			out_tag_q  <= res_tag_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = out_acc_q;
	assign fired      = out_fire_q;
	assign slot_index = out_idx_q;
	assign fired_tag  = out_tag_q;

	// a taken request always moves the sequencer out of idle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q != S_IDLE)
		else $error("request taken but sequencer stayed idle");

	// an insert and an expiry never share one result
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_acc_q && out_fire_q))
		else $error("result flags both insert and expiry");

	// a tag is only reported with an expiry
	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_fire_q) |-> out_tag_q == '0)
		else $error("tag reported without expiry");

	// the walk never runs past the last slot
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> eidx_q <= IDX_W'(SLOT_COUNT - 1))
		else $error("walk index past last slot");

endmodule
